@@ hdl/lpc_pkg.sv @@
`default_nettype none
package lpc_pkg;

    localparam int MACHINES = 32;
    localparam int RACKS    = 8;
    localparam int CNT_W    = 24;
    localparam int COST_W   = 40;
    localparam int THR_W    = 17;
    localparam int PROD_W   = THR_W + CNT_W;
    localparam int RIW      = (RACKS > 1) ? $clog2(RACKS) : 1;
    localparam int SEQ_W    = $clog2(MACHINES + 1);

    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    localparam logic [1:0] KIND_MACHINE = 2'd0;
    localparam logic [1:0] KIND_RACK    = 2'd1;
    localparam logic [1:0] KIND_CLUSTER = 2'd2;

    localparam logic [1:0] CFG_MACH_THR  = 2'd0;
    localparam logic [1:0] CFG_RACK_THR  = 2'd1;
    localparam logic [1:0] CFG_CORE_COST = 2'd2;
    localparam logic [1:0] CFG_RACK_COST = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MACH,
        ST_RACK,
        ST_CLUS
    } seq_state_t;

    typedef struct packed {
        logic        vld;
        logic [15:0] blocks;
        logic [4:0]  mach;
        logic [2:0]  rack;
        logic        close;
    } rec_t;

    typedef struct packed {
        logic             vld;
        logic [1:0]       kind;
        logic [4:0]       idx;
        logic [CNT_W-1:0] cnt;
        logic             seen;
        logic [2:0]       rk;
    } head_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [15:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W-15){1'b0}}, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sub0(input logic [CNT_W-1:0] a,
                                              input logic [CNT_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage
`default_nettype wire

@@ hdl/locality_preference_cost_top.sv @@
// Locality preference cost unit.
// Records enter on start/busy: one replica record per accepted cycle, with
// file_blocks, machine_index, rack_index, file_end and task_end. A record
// without task_end is taken and busy stays low.
// A record with task_end raises busy: the prep state forms the share limits,
// then the machine cells shift their counts to the head of the chain one per
// cycle, then the rack cells do the same, then the cluster entry is formed.
// Each entry is checked at the head of its chain and goes through a
// three-stage cost pipeline; qualifying entries appear on result_valid in
// index order, machines first, racks next, the cluster entry last with
// last_entry set.
// The shifts fill the chains with zeros, so counts are clear when busy drops.
// Results are shown for one cycle each; the receiver cannot stall them.
// Registers are written via cfg_valid/cfg_index/cfg_data (cfg_ready is always
// high); the user must write only while the unit is idle; it is not enforced.
// Reset clears all counts and the configuration registers; no result is pending after reset.
`default_nettype none
module locality_preference_cost_top (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire [15:0]                 file_blocks,
    input  wire [4:0]                  machine_index,
    input  wire [2:0]                  rack_index,
    input  wire                        file_end,
    input  wire                        task_end,
    input  wire                        cfg_valid,
    output logic                       cfg_ready,
    input  wire [1:0]                  cfg_index,
    input  wire [16:0]                 cfg_data,
    output logic                       result_valid,
    output logic [1:0]                 entry_kind,
    output logic [4:0]                 entry_index,
    output logic [lpc_pkg::COST_W-1:0] transfer_cost,
    output logic                       last_entry
);
    import lpc_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [THR_W-1:0]  mthr_reg, rthr_reg;
    logic [15:0]       ccost_reg, rcost_reg;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic              counted_reg, counted_next;
    logic [PROD_W-1:0] mlim_reg, rlim_reg;
    logic              accept;
    rec_t              rec;
    head_t             head;
    logic              mshift, rshift;

    logic [CNT_W-1:0]  m_cnt  [MACHINES+1];
    logic              m_seen [MACHINES+1];
    logic [2:0]        m_rack [MACHINES+1];
    logic [CNT_W-1:0]  r_cnt  [RACKS+1];
    logic              r_seen [RACKS+1];
    logic [CNT_W-1:0]  r_tab  [RACKS];

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        rec.vld    = accept;
        rec.blocks = file_blocks;
        rec.mach   = machine_index;
        rec.rack   = rack_index;
        rec.close  = file_end || task_end;
    end

    assign m_cnt[MACHINES]  = '0;
    assign m_seen[MACHINES] = 1'b0;
    assign m_rack[MACHINES] = '0;
    assign r_cnt[RACKS]     = '0;
    assign r_seen[RACKS]    = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < MACHINES; gi++)
        begin : g_mach
            lpc_mcell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .my_idx    (5'(gi)),
                .rec       (rec),
                .shift     (mshift),
                .prev_cnt  (m_cnt[gi+1]),
                .prev_seen (m_seen[gi+1]),
                .prev_rack (m_rack[gi+1]),
                .cnt       (m_cnt[gi]),
                .seen      (m_seen[gi]),
                .rack      (m_rack[gi])
            );
        end
        for (gi = 0; gi < RACKS; gi++)
        begin : g_rack
            lpc_rcell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .my_idx    (3'(gi)),
                .rec       (rec),
                .shift     (rshift),
                .prev_cnt  (r_cnt[gi+1]),
                .prev_seen (r_seen[gi+1]),
                .cnt       (r_cnt[gi]),
                .seen      (r_seen[gi])
            );
            assign r_tab[gi] = r_cnt[gi];
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        seq_next   = seq_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && task_end)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_MACH;
                seq_next   = '0;
            end
            ST_MACH:
            begin
                seq_next = seq_reg + 1'b1;
                if (32'(seq_reg) == MACHINES - 1)
                begin
                    state_next = ST_RACK;
                    seq_next   = '0;
                end
            end
            ST_RACK:
            begin
                seq_next = seq_reg + 1'b1;
                if (32'(seq_reg) == RACKS - 1)
                begin
                    state_next = ST_CLUS;
                end
            end
            ST_CLUS:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        mshift    = (state_reg == ST_MACH);
        rshift    = (state_reg == ST_RACK);
        head.vld  = 1'b0;
        head.kind = KIND_CLUSTER;
        head.idx  = 5'(seq_reg);
        head.cnt  = m_cnt[0];
        head.seen = m_seen[0];
        head.rk   = m_rack[0];
        case (state_reg)
            ST_MACH:
            begin
                head.vld  = 1'b1;
                head.kind = KIND_MACHINE;
            end
            ST_RACK:
            begin
                head.vld  = 1'b1;
                head.kind = KIND_RACK;
                head.cnt  = r_cnt[0];
                head.seen = r_seen[0];
            end
            ST_CLUS:
            begin
                head.vld  = 1'b1;
                head.idx  = '0;
            end
            default:
            begin
                head.vld  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        total_next   = total_reg;
        counted_next = counted_reg;
        if (accept)
        begin
            if (!counted_reg)
            begin
                total_next   = sat_add(total_reg, file_blocks);
                counted_next = 1'b1;
            end
            if (file_end || task_end)
            begin
                counted_next = 1'b0;
            end
        end
        else if (state_reg == ST_CLUS)
        begin
            total_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            seq_reg     <= '0;
            total_reg   <= '0;
            counted_reg <= 1'b0;
            mthr_reg    <= '0;
            rthr_reg    <= '0;
            ccost_reg   <= '0;
            rcost_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            seq_reg     <= seq_next;
            total_reg   <= total_next;
            counted_reg <= counted_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MACH_THR:  mthr_reg  <= cfg_data;
                    CFG_RACK_THR:  rthr_reg  <= cfg_data;
                    CFG_CORE_COST: ccost_reg <= cfg_data[15:0];
                    CFG_RACK_COST: rcost_reg <= cfg_data[15:0];
                    default:       mthr_reg  <= mthr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PREP)
        begin
            mlim_reg <= {{CNT_W{1'b0}}, mthr_reg} * {{THR_W{1'b0}}, total_reg};
            rlim_reg <= {{CNT_W{1'b0}}, rthr_reg} * {{THR_W{1'b0}}, total_reg};
        end
    end

    lpc_eval u_eval (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .total         (total_reg),
        .mach_lim      (mlim_reg),
        .rack_lim      (rlim_reg),
        .rack_cnt      (r_tab),
        .core_cost     (ccost_reg),
        .rack_cost     (rcost_reg),
        .result_valid  (result_valid),
        .entry_kind    (entry_kind),
        .entry_index   (entry_index),
        .transfer_cost (transfer_cost),
        .last_entry    (last_entry)
    );

    a_last_timing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_entry |-> $past(state_reg == ST_CLUS, 3))
        else $error("last word not three cycles after cluster step");

    a_task_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && task_end |=> state_reg == ST_PREP)
        else $error("task end did not start the walk");

    a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MACH || state_reg == ST_RACK) |=> $stable(total_reg))
        else $error("total changed during the walk");

    a_walk_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLUS |=> !m_seen[0] && !r_seen[0] && total_reg == '0)
        else $error("counts not cleared after the walk");
endmodule
`default_nettype wire

@@ hdl/lpc_mcell.sv @@
`default_nettype none
module lpc_mcell (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire [4:0]                 my_idx,
    input  lpc_pkg::rec_t             rec,
    input  wire                       shift,
    input  wire [lpc_pkg::CNT_W-1:0]  prev_cnt,
    input  wire                       prev_seen,
    input  wire [2:0]                 prev_rack,
    output logic [lpc_pkg::CNT_W-1:0] cnt,
    output logic                      seen,
    output logic [2:0]                rack
);
    import lpc_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             seen_reg, seen_next;
    logic [2:0]       rack_reg, rack_next;

    always_comb
    begin
        cnt_next  = cnt_reg;
        seen_next = seen_reg;
        rack_next = rack_reg;
        if (shift)
        begin
            cnt_next  = prev_cnt;
            seen_next = prev_seen;
            rack_next = prev_rack;
        end
        else if (rec.vld && rec.mach == my_idx)
        begin
            cnt_next  = sat_add(cnt_reg, rec.blocks);
            seen_next = 1'b1;
            rack_next = rec.rack;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            seen_reg <= 1'b0;
            rack_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            seen_reg <= seen_next;
            rack_reg <= rack_next;
        end
    end

    assign cnt  = cnt_reg;
    assign seen = seen_reg;
    assign rack = rack_reg;
endmodule
`default_nettype wire

@@ hdl/lpc_rcell.sv @@
`default_nettype none
module lpc_rcell (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire [2:0]                 my_idx,
    input  lpc_pkg::rec_t             rec,
    input  wire                       shift,
    input  wire [lpc_pkg::CNT_W-1:0]  prev_cnt,
    input  wire                       prev_seen,
    output logic [lpc_pkg::CNT_W-1:0] cnt,
    output logic                      seen
);
    import lpc_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             seen_reg, seen_next;
    logic             infile_reg, infile_next;

    always_comb
    begin
        cnt_next    = cnt_reg;
        seen_next   = seen_reg;
        infile_next = infile_reg;
        if (shift)
        begin
            cnt_next  = prev_cnt;
            seen_next = prev_seen;
        end
        else if (rec.vld)
        begin
            if (rec.rack == my_idx)
            begin
                seen_next = 1'b1;
                if (!infile_reg)
                begin
                    cnt_next    = sat_add(cnt_reg, rec.blocks);
                    infile_next = 1'b1;
                end
            end
            if (rec.close)
            begin
                infile_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            seen_reg   <= 1'b0;
            infile_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            seen_reg   <= seen_next;
            infile_reg <= infile_next;
        end
    end

    assign cnt  = cnt_reg;
    assign seen = seen_reg;
endmodule
`default_nettype wire

@@ hdl/lpc_eval.sv @@
`default_nettype none
module lpc_eval (
    input  wire                        clk,
    input  wire                        rst_n,
    input  lpc_pkg::head_t             head,
    input  wire [lpc_pkg::CNT_W-1:0]   total,
    input  wire [lpc_pkg::PROD_W-1:0]  mach_lim,
    input  wire [lpc_pkg::PROD_W-1:0]  rack_lim,
    input  wire [lpc_pkg::CNT_W-1:0]   rack_cnt [lpc_pkg::RACKS],
    input  wire [15:0]                 core_cost,
    input  wire [15:0]                 rack_cost,
    output logic                       result_valid,
    output logic [1:0]                 entry_kind,
    output logic [4:0]                 entry_index,
    output logic [lpc_pkg::COST_W-1:0] transfer_cost,
    output logic                       last_entry
);
    import lpc_pkg::*;

    logic [PROD_W-1:0] scaled;
    logic              qual;
    logic [CNT_W-1:0]  own_rack, core_b, rack_b;

    logic              v1_reg, l1_reg;
    logic [1:0]        k1_reg;
    logic [4:0]        i1_reg;
    logic [CNT_W-1:0]  core1_reg, rack1_reg;
    logic              v2_reg, l2_reg;
    logic [1:0]        k2_reg;
    logic [4:0]        i2_reg;
    logic [COST_W-1:0] pc2_reg, pr2_reg;
    logic              v3_reg, l3_reg;
    logic [1:0]        k3_reg;
    logic [4:0]        i3_reg;
    logic [COST_W-1:0] cost3_reg;
    logic [COST_W:0]   sum;

    always_comb
    begin
        scaled   = {{(PROD_W-CNT_W-16){1'b0}}, head.cnt, 16'd0};
        own_rack = (32'(head.rk) < RACKS) ? rack_cnt[head.rk[RIW-1:0]] : '0;
        qual     = 1'b0;
        core_b   = total;
        rack_b   = '0;
        case (head.kind)
            KIND_MACHINE:
            begin
                qual   = head.seen && (total != '0) && (scaled >= mach_lim);
                rack_b = (32'(head.rk) < RACKS) ? sub0(own_rack, head.cnt) : '0;
                core_b = sub0(sub0(total, rack_b), head.cnt);
            end
            KIND_RACK:
            begin
                qual   = head.seen && (total != '0) && (scaled > rack_lim);
                rack_b = head.cnt;
                core_b = sub0(total, head.cnt);
            end
            default:
            begin
                qual = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= head.vld && qual;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign sum = {1'b0, pc2_reg} + {1'b0, pr2_reg};

    always_ff @(posedge clk)
    begin
        l1_reg    <= (head.kind == KIND_CLUSTER);
        k1_reg    <= head.kind;
        i1_reg    <= head.idx;
        core1_reg <= core_b;
        rack1_reg <= rack_b;
        l2_reg    <= l1_reg;
        k2_reg    <= k1_reg;
        i2_reg    <= i1_reg;
        pc2_reg   <= COST_W'({16'd0, core1_reg} * {24'd0, core_cost});
        pr2_reg   <= COST_W'({16'd0, rack1_reg} * {24'd0, rack_cost});
        l3_reg    <= l2_reg;
        k3_reg    <= k2_reg;
        i3_reg    <= i2_reg;
        cost3_reg <= sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
    end

    assign result_valid  = v3_reg;
    assign entry_kind    = k3_reg;
    assign entry_index   = i3_reg;
    assign transfer_cost = cost3_reg;
    assign last_entry    = l3_reg;
endmodule
`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none
module tb;
    import lpc_pkg::*;

    typedef struct {
        logic [15:0] blocks;
        logic [4:0]  mach;
        logic [2:0]  rack;
        logic        fend;
        logic        tend;
    } replica_t;

    typedef struct {
        logic [1:0]        kind;
        logic [4:0]        idx;
        logic [COST_W-1:0] cost;
        logic              last;
    } entry_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [15:0] file_blocks = '0;
    logic [4:0] machine_index = '0;
    logic [2:0] rack_index = '0;
    logic file_end = 1'b0;
    logic task_end = 1'b0;
    logic cfg_valid = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [16:0] cfg_data = '0;
    logic busy, cfg_ready, result_valid, last_entry;
    logic [1:0] entry_kind;
    logic [4:0] entry_index;
    logic [COST_W-1:0] transfer_cost;

    replica_t pending_replicas[$];
    entry_t   expected_entries[$];
    int       errors = 0;
    bit       steady = 1'b0;

    logic [16:0] mach_thr, rack_thr;
    logic [15:0] core_cost, rack_cost;
    logic [CNT_W-1:0] mach_cnt[MACHINES];
    logic             mach_seen[MACHINES];
    logic [2:0]       mach_rack[MACHINES];
    logic [CNT_W-1:0] rack_cnt[RACKS];
    logic             rack_seen_q[RACKS];
    logic [7:0]       file_racks;
    logic [CNT_W-1:0] total_cnt;
    logic             file_open;

    locality_preference_cost_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .file_blocks(file_blocks), .machine_index(machine_index),
        .rack_index(rack_index), .file_end(file_end), .task_end(task_end),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .entry_kind(entry_kind),
        .entry_index(entry_index), .transfer_cost(transfer_cost),
        .last_entry(last_entry)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] cnt_add(logic [CNT_W-1:0] a, logic [15:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W-15){1'b0}}, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] floor_sub(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic logic [COST_W-1:0] move_cost(logic [CNT_W-1:0] cb, logic [CNT_W-1:0] rb);
        logic [63:0] c;
        c = 64'(cb) * 64'(core_cost) + 64'(rb) * 64'(rack_cost);
        return (c > 64'hFF_FFFF_FFFF) ? {COST_W{1'b1}} : c[COST_W-1:0];
    endfunction

    task automatic clear_counts();
        int i;
        for (i = 0; i < MACHINES; i++)
        begin
            mach_cnt[i] = '0;
            mach_seen[i] = 1'b0;
            mach_rack[i] = '0;
        end
        for (i = 0; i < RACKS; i++)
        begin
            rack_cnt[i] = '0;
            rack_seen_q[i] = 1'b0;
        end
        file_racks = '0;
        total_cnt = '0;
        file_open = 1'b0;
    endtask

    task automatic push_entry(logic [1:0] k, logic [4:0] ix, logic [COST_W-1:0] c, logic l);
        entry_t e;
        e.kind = k;
        e.idx = ix;
        e.cost = c;
        e.last = l;
        expected_entries = {expected_entries, e};
    endtask

    task automatic locality_predict(replica_t it);
        int i;
        logic [CNT_W-1:0] c, rb, cb;
        logic [63:0] tot;
        if (!file_open)
        begin
            total_cnt = cnt_add(total_cnt, it.blocks);
            file_open = 1'b1;
        end
        mach_cnt[it.mach] = cnt_add(mach_cnt[it.mach], it.blocks);
        mach_seen[it.mach] = 1'b1;
        mach_rack[it.mach] = it.rack;
        if (!file_racks[it.rack])
        begin
            rack_cnt[it.rack] = cnt_add(rack_cnt[it.rack], it.blocks);
            file_racks[it.rack] = 1'b1;
        end
        rack_seen_q[it.rack] = 1'b1;
        if (it.fend || it.tend)
        begin
            file_racks = '0;
            file_open = 1'b0;
        end
        if (!it.tend)
            return;
        tot = 64'(total_cnt);
        if (tot != 0)
        begin
            for (i = 0; i < MACHINES; i++)
            begin
                c = mach_cnt[i];
                if (mach_seen[i] && (64'(c) * 65536 >= 64'(mach_thr) * tot))
                begin
                    rb = floor_sub(rack_cnt[mach_rack[i]], c);
                    cb = floor_sub(floor_sub(total_cnt, rb), c);
                    push_entry(KIND_MACHINE, i[4:0], move_cost(cb, rb), 1'b0);
                end
            end
            for (i = 0; i < RACKS; i++)
            begin
                c = rack_cnt[i];
                if (rack_seen_q[i] && (64'(c) * 65536 > 64'(rack_thr) * tot))
                    push_entry(KIND_RACK, i[4:0], move_cost(floor_sub(total_cnt, c), c), 1'b0);
            end
        end
        push_entry(KIND_CLUSTER, 5'd0, move_cost(total_cnt, '0), 1'b1);
        clear_counts();
    endtask

    always @(negedge clk)
    begin
        if (rst_n && pending_replicas.size() != 0 &&
            (steady || $urandom_range(0, 99) >= 9))
        begin
            start <= 1'b1;
            file_blocks <= pending_replicas[0].blocks;
            machine_index <= pending_replicas[0].mach;
            rack_index <= pending_replicas[0].rack;
            file_end <= pending_replicas[0].fend;
            task_end <= pending_replicas[0].tend;
        end
        else
            start <= 1'b0;
    end

    always @(posedge clk)
    begin
        entry_t e;
        if (rst_n && start && !busy)
        begin
            locality_predict(pending_replicas[0]);
            void'(pending_replicas.pop_front());
        end
        if (rst_n && result_valid)
        begin
            if (expected_entries.size() == 0)
            begin
                errors++;
                $display("%0t unexpected word kind %0d index %0d cost %0d", $time,
                         entry_kind, entry_index, transfer_cost);
            end
            else
            begin
                e = expected_entries.pop_front();
                if (e.kind !== entry_kind)
                begin
                    errors++;
                    $display("%0t entry_kind expected %0d actual %0d", $time, e.kind, entry_kind);
                end
                if (e.idx !== entry_index)
                begin
                    errors++;
                    $display("%0t entry_index expected %0d actual %0d", $time, e.idx, entry_index);
                end
                if (e.cost !== transfer_cost)
                begin
                    errors++;
                    $display("%0t transfer_cost expected %0d actual %0d", $time, e.cost,
                             transfer_cost);
                end
                if (e.last !== last_entry)
                begin
                    errors++;
                    $display("%0t last_entry expected %0d actual %0d", $time, e.last, last_entry);
                end
            end
        end
    end

    task automatic write_reg(logic [1:0] ix, logic [16:0] d);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = ix;
        cfg_data = d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (ix)
            CFG_MACH_THR:  mach_thr = d;
            CFG_RACK_THR:  rack_thr = d;
            CFG_CORE_COST: core_cost = d[15:0];
            default:       rack_cost = d[15:0];
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_regs(logic [16:0] mt, logic [16:0] rt, logic [15:0] cc, logic [15:0] rc);
        write_reg(CFG_MACH_THR, mt);
        write_reg(CFG_RACK_THR, rt);
        write_reg(CFG_CORE_COST, {1'b0, cc});
        write_reg(CFG_RACK_COST, {1'b0, rc});
    endtask

    task automatic add_rec(logic [15:0] b, logic [4:0] m, logic [2:0] r, logic fe, logic te);
        replica_t it;
        it.blocks = b;
        it.mach = m;
        it.rack = r;
        it.fend = fe;
        it.tend = te;
        pending_replicas = {pending_replicas, it};
    endtask

    function automatic logic [15:0] pick_blocks();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 15));
            1: return 16'($urandom);
            2: return 16'hFFFF;
            default: return 16'($urandom_range(1, 300));
        endcase
    endfunction

    task automatic add_job(int nrec, bit heavy);
        int i, left;
        logic [15:0] fb, b;
        logic [4:0] m;
        left = 0;
        fb = '0;
        for (i = 0; i < nrec; i++)
        begin
            if (left == 0)
            begin
                left = $urandom_range(1, 4);
                fb = heavy ? 16'hFFFF : pick_blocks();
            end
            b = ($urandom_range(0, 9) == 0) ? 16'($urandom) : fb;
            m = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
            left--;
            add_rec(b, m, 3'($urandom), (left == 0) ^ ($urandom_range(0, 19) == 0),
                    i == nrec - 1);
        end
    endtask

    task automatic drain();
        while (pending_replicas.size() != 0 || expected_entries.size() != 0 || busy)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        int p, k;
        mach_thr = '0;
        rack_thr = '0;
        core_cost = '0;
        rack_cost = '0;
        clear_counts();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_rec(16'd0, 5'd0, 3'd0, 1'b0, 1'b1);
        add_rec(16'd7, 5'd3, 3'd1, 1'b1, 1'b1);
        drain();
        set_regs(17'd0, 17'd0, 16'hFFFF, 16'hFFFF);
        add_rec(16'hFFFF, 5'd31, 3'd7, 1'b0, 1'b0);
        add_rec(16'd5, 5'd0, 3'd7, 1'b1, 1'b0);
        add_rec(16'd9, 5'd31, 3'd0, 1'b0, 1'b0);
        add_rec(16'd9, 5'd31, 3'd0, 1'b1, 1'b0);
        add_rec(16'd100, 5'd10, 3'd2, 1'b0, 1'b0);
        add_rec(16'd200, 5'd11, 3'd2, 1'b0, 1'b0);
        add_rec(16'd300, 5'd12, 3'd3, 1'b0, 1'b1);
        drain();
        set_regs(17'd65536, 17'd65536, 16'd1, 16'd0);
        add_rec(16'd40, 5'd1, 3'd4, 1'b1, 1'b0);
        add_rec(16'd40, 5'd1, 3'd4, 1'b0, 1'b1);
        add_rec(16'hFFFF, 5'd2, 3'd5, 1'b1, 1'b1);
        drain();
        set_regs(17'd32768, 17'd32768, 16'hFFFF, 16'h0001);
        add_job(50, 1'b1);
        drain();

        for (p = 0; p < 6; p++)
        begin
            case (p)
                0: set_regs(17'd0, 17'd0, 16'($urandom), 16'($urandom));
                1: set_regs(17'd65536, 17'd65536, 16'hFFFF, 16'hFFFF);
                2: set_regs(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
                            16'($urandom), 16'($urandom));
                3: set_regs(17'($urandom_range(0, 20000)), 17'($urandom_range(0, 30000)),
                            16'd0, 16'($urandom));
                4: set_regs(17'($urandom), 17'($urandom), 16'($urandom), 16'd0);
                default: set_regs(17'($urandom_range(5000, 40000)),
                                  17'($urandom_range(5000, 40000)),
                                  16'($urandom), 16'($urandom));
            endcase
            steady = (p == 2);
            for (k = 0; k < 4; k++)
                add_job($urandom_range(1, 12), 1'b0);
            drain();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #(12 * 400000);
        $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
